// ===== src/ppc_pkg.sv =====
`timescale 1ns / 1ps

package ppc_pkg;

  localparam int unsigned PosW     = 32;
  localparam int unsigned LaneW    = 16;
  localparam int unsigned GapW     = 34;
  localparam int unsigned AngW     = 16;
  localparam int unsigned RadW     = 66;
  localparam int unsigned MagW     = 33;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 34;
  localparam int unsigned CordicSteps = 24;
  localparam logic [AngW-1:0] AngleMax = 16'd51472;

  localparam logic [CfgIdxW-1:0] CfgDistanceLimit = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgAngleLimit    = 8'd1;

  localparam logic [GapW-1:0] DistanceLimitRst = 34'd65536;
  localparam logic [AngW-1:0] AngleLimitRst    = 16'd1638;

  // arctan(2^-i) in Q0.30, truncated
  localparam logic [29:0] AtanTab [CordicSteps] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
  };

  typedef struct packed {
    logic signed [PosW-1:0] first_x;
    logic signed [PosW-1:0] first_y;
    logic signed [PosW-1:0] first_z;
    logic [4*LaneW-1:0]     first_quat;
    logic signed [PosW-1:0] second_x;
    logic signed [PosW-1:0] second_y;
    logic signed [PosW-1:0] second_z;
    logic [4*LaneW-1:0]     second_quat;
  } in_t;

  typedef struct packed {
    logic [GapW-1:0] position_gap;
    logic [AngW-1:0] rotation_gap;
    logic            position_near;
    logic            rotation_near;
    logic            pose_near;
  } out_t;

endpackage

// ===== src/ppc_front.sv =====
`timescale 1ns / 1ps

module ppc_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  ppc_pkg::in_t            data_i,
  output logic                    valid_o,
  output logic [ppc_pkg::RadW-1:0] pos_rad_o,
  output logic [ppc_pkg::RadW-1:0] quat_rad_o,
  output logic [ppc_pkg::MagW-1:0] u_o
);
  import ppc_pkg::*;

  logic [3:0] valid_q;

  logic signed [PosW:0]       dx_q [3];
  logic signed [2*LaneW-1:0]  prod_q [4][4];
  logic [RadW-1:0]            psq_q [3];
  logic signed [MagW:0]       qc_q [4];
  logic [RadW-1:0]            psum_q;
  logic [RadW-1:0]            qsq_q [3];
  logic [MagW-1:0]            u3_q;
  logic [RadW-1:0]            pos_rad_q;
  logic [RadW-1:0]            quat_rad_q;
  logic [MagW-1:0]            u4_q;

  logic signed [PosW-1:0]  pa [3];
  logic signed [PosW-1:0]  pb [3];
  logic signed [LaneW-1:0] qa [4];
  logic signed [LaneW-1:0] qb [4];
  logic signed [MagW:0]    pe [4][4];

  assign pa[0] = data_i.first_x;
  assign pa[1] = data_i.first_y;
  assign pa[2] = data_i.first_z;
  assign pb[0] = data_i.second_x;
  assign pb[1] = data_i.second_y;
  assign pb[2] = data_i.second_z;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    assign qa[k] = data_i.first_quat[4*LaneW-1-LaneW*k -: LaneW];
    assign qb[k] = data_i.second_quat[4*LaneW-1-LaneW*k -: LaneW];
    for (genvar j = 0; j < 4; j++) begin : g_ext
      assign pe[k][j] = (MagW+1)'(prod_q[k][j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: position differences, lane products
      for (int k = 0; k < 3; k++) begin
        dx_q[k] <= (PosW+1)'(pa[k]) - (PosW+1)'(pb[k]);
      end
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_q[i][j] <= (2*LaneW)'(qa[i]) * (2*LaneW)'(qb[j]);
        end
      end
      // stage 2: squares, components of q1 * conj(q2)
      for (int k = 0; k < 3; k++) begin
        psq_q[k] <= RadW'(RadW'(dx_q[k]) * RadW'(dx_q[k]));
      end
      qc_q[0] <= pe[0][0] + pe[1][1] + pe[2][2] + pe[3][3];
      qc_q[1] <= -pe[0][1] + pe[1][0] - pe[2][3] + pe[3][2];
      qc_q[2] <= -pe[0][2] + pe[1][3] + pe[2][0] - pe[3][1];
      qc_q[3] <= -pe[0][3] - pe[1][2] + pe[2][1] + pe[3][0];
      // stage 3
      psum_q <= psq_q[0] + psq_q[1] + psq_q[2];
      for (int k = 0; k < 3; k++) begin
        qsq_q[k] <= RadW'(RadW'(qc_q[k+1]) * RadW'(qc_q[k+1]));
      end
      u3_q <= qc_q[0][MagW] ? MagW'(-qc_q[0]) : MagW'(qc_q[0]);
      // stage 4
      pos_rad_q  <= psum_q;
      quat_rad_q <= qsq_q[0] + qsq_q[1] + qsq_q[2];
      u4_q       <= u3_q;
    end
  end

  assign valid_o    = valid_q[3];
  assign pos_rad_o  = pos_rad_q;
  assign quat_rad_o = quat_rad_q;
  assign u_o        = u4_q;

endmodule

// ===== src/ppc_isqrt.sv =====
`timescale 1ns / 1ps

module ppc_isqrt #(
  parameter int unsigned N     = 34,
  parameter int unsigned SideW = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [2*N-1:0]   rad_a_i,
  input  logic [2*N-1:0]   rad_b_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [N-1:0]     root_a_o,
  output logic [N-1:0]     root_b_o,
  output logic [SideW-1:0] side_o
);

  logic             valid_q [N];
  logic [SideW-1:0] side_q  [N];
  logic [2*N-1:0]   rad_q   [N][2];
  logic [N+2:0]     rem_q   [N][2];
  logic [N-1:0]     root_q  [N][2];

  // one root bit per stage, restoring digit recurrence
  for (genvar s = 0; s < N; s++) begin : g_stage
    logic             pv;
    logic [SideW-1:0] ps;

    if (s == 0) begin : g_first
      assign pv = valid_i;
      assign ps = side_i;
    end else begin : g_next
      assign pv = valid_q[s-1];
      assign ps = side_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= ps;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [2*N-1:0] prad;
      logic [N+2:0]   prem;
      logic [N-1:0]   proot;
      logic [N+2:0]   cat;
      logic [N+2:0]   trial;
      logic           take;

      if (s == 0) begin : g_first
        assign prad  = (l == 0) ? rad_a_i : rad_b_i;
        assign prem  = '0;
        assign proot = '0;
      end else begin : g_next
        assign prad  = rad_q[s-1][l];
        assign prem  = rem_q[s-1][l];
        assign proot = root_q[s-1][l];
      end

      assign cat   = {prem[N:0], prad[2*N-1 -: 2]};
      assign trial = {1'b0, proot, 2'b01};
      assign take  = (cat >= trial);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[s][l]  <= {prad[2*N-3:0], 2'b00};
          rem_q[s][l]  <= take ? (cat - trial) : cat;
          root_q[s][l] <= {proot[N-2:0], take};
        end
      end
    end
  end

  assign valid_o  = valid_q[N-1];
  assign side_o   = side_q[N-1];
  assign root_a_o = root_q[N-1][0];
  assign root_b_o = root_q[N-1][1];

endmodule

// ===== src/ppc_cordic.sv =====
`timescale 1ns / 1ps

module ppc_cordic (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [ppc_pkg::GapW-1:0] gap_i,
  input  logic [ppc_pkg::GapW-1:0] v_i,
  input  logic [ppc_pkg::MagW-1:0] u_i,
  input  logic [ppc_pkg::GapW-1:0] dist_lim_i,
  input  logic [ppc_pkg::AngW-1:0] ang_lim_i,
  output logic                     valid_o,
  output ppc_pkg::out_t            data_o
);
  import ppc_pkg::*;

  localparam int unsigned Steps = CordicSteps;
  localparam int unsigned NormW = 41;
  localparam int unsigned XW    = 45;
  localparam int unsigned ZW    = 34;

  logic                valid_q [Steps+3];
  logic [GapW-1:0]     gap_q   [Steps+2];
  logic                zero_q  [Steps+2];

  logic [GapW-1:0]     u_a_q;
  logic [GapW-1:0]     v_a_q;
  logic [5:0]          sh_q;
  logic signed [XW-1:0] x_q [Steps+1];
  logic signed [XW-1:0] y_q [Steps+1];
  logic signed [ZW-1:0] z_q [Steps+1];
  out_t                out_q;

  logic [GapW-1:0] uv;
  logic [5:0]      msb;

  assign uv = {1'b0, u_i} | v_i;

  always_comb begin
    msb = '0;
    for (int b = 0; b < GapW; b++) begin
      if (uv[b]) msb = 6'(b);
    end
  end

  // valid chain: normalize count, shift, iterations, rounding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Steps+3; s++) valid_q[s] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int s = 1; s < Steps+3; s++) valid_q[s] <= valid_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gap_q[0]  <= gap_i;
      zero_q[0] <= (v_i == '0);
      u_a_q     <= {1'b0, u_i};
      v_a_q     <= v_i;
      sh_q      <= 6'(NormW - 1) - msb;
      for (int s = 1; s < Steps+2; s++) begin
        gap_q[s]  <= gap_q[s-1];
        zero_q[s] <= zero_q[s-1];
      end
      x_q[0] <= XW'({{(XW-GapW){1'b0}}, u_a_q} << sh_q);
      y_q[0] <= XW'({{(XW-GapW){1'b0}}, v_a_q} << sh_q);
      z_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_iter
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] at;
    logic                 pos;

    assign xs  = x_q[i] >>> i;
    assign ys  = y_q[i] >>> i;
    assign at  = ZW'(AtanTab[i]);
    assign pos = (y_q[i] > 0);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1] <= pos ? (x_q[i] + ys) : (x_q[i] - ys);
        y_q[i+1] <= pos ? (y_q[i] - xs) : (y_q[i] + xs);
        z_q[i+1] <= pos ? (z_q[i] + at) : (z_q[i] - at);
      end
    end
  end

  logic [ZW:0]     rnd;
  logic [AngW-1:0] rot;
  logic [GapW-1:0] gap_f;
  logic            pn;
  logic            rn;

  assign rnd   = {z_q[Steps], 1'b0} + (ZW+1)'(32768);
  assign gap_f = gap_q[Steps+1];

  always_comb begin
    if (zero_q[Steps+1] || z_q[Steps][ZW-1]) begin
      rot = '0;
    end else if (rnd[ZW:16] > (ZW-15)'(AngleMax)) begin
      rot = AngleMax;
    end else begin
      rot = AngW'(rnd[ZW:16]);
    end
  end

  assign pn = (gap_f < dist_lim_i);
  assign rn = (rot < ang_lim_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.position_gap  <= gap_f;
      out_q.rotation_gap  <= rot;
      out_q.position_near <= pn;
      out_q.rotation_near <= rn;
      out_q.pose_near     <= pn & rn;
    end
  end

  assign valid_o = valid_q[Steps+2];
  assign data_o  = out_q;

endmodule

// ===== src/pose_proximity_check_top.sv =====
`timescale 1ns / 1ps
// Throughput: one pose pair per cycle; a stalled output holds the whole pipeline.
// Depth is set by two 34-stage square-root pipelines and a 24-stage CORDIC.
// Reset (rst_ni low, async): all stage valid bits clear, limits return to
// 1.0 (distance) and 1638/16384 rad (angle); payload registers are not reset.

module pose_proximity_check_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ppc_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ppc_pkg::out_t                out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ppc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ppc_pkg::CfgDataW-1:0] cfg_data_i
);
  import ppc_pkg::*;

  logic [GapW-1:0] dist_lim_q;
  logic [AngW-1:0] ang_lim_q;

  // Configuration writes are always taken; the limits feed only the final
  // compare stage.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_lim_q <= DistanceLimitRst;
      ang_lim_q  <= AngleLimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgDistanceLimit: dist_lim_q <= cfg_data_i;
        CfgAngleLimit:    ang_lim_q  <= cfg_data_i[AngW-1:0];
        default: ;
      endcase
    end
  end

  // Advance every stage together unless a finished result waits on the
  // output; bubbles move freely when the output is empty.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic            f_valid;
  logic [RadW-1:0] f_pos_rad;
  logic [RadW-1:0] f_quat_rad;
  logic [MagW-1:0] f_u;

  // Stages 1-4: position differences and squares, quaternion product
  // q1 * conj(q2), the squared norm of its vector part and |w|.
  ppc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .data_i     (in_data_i),
    .valid_o    (f_valid),
    .pos_rad_o  (f_pos_rad),
    .quat_rad_o (f_quat_rad),
    .u_o        (f_u)
  );

  logic            s_valid;
  logic [GapW-1:0] s_gap;
  logic [GapW-1:0] s_v;
  logic [MagW-1:0] s_u;

  // Stages 5-38: both square roots side by side, |w| rides along.
  ppc_isqrt #(
    .N     (GapW),
    .SideW (MagW)
  ) u_isqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (f_valid),
    .rad_a_i  ({2'b00, f_pos_rad}),
    .rad_b_i  ({2'b00, f_quat_rad}),
    .side_i   (f_u),
    .valid_o  (s_valid),
    .root_a_o (s_gap),
    .root_b_o (s_v),
    .side_o   (s_u)
  );

  // Stages 39-65: normalize, 24 vectoring steps, round, clamp and compare.
  ppc_cordic u_cordic (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s_valid),
    .gap_i      (s_gap),
    .v_i        (s_v),
    .u_i        (s_u),
    .dist_lim_i (dist_lim_q),
    .ang_lim_i  (ang_lim_q),
    .valid_o    (out_valid_o),
    .data_o     (out_data_o)
  );

endmodule

// ===== src/ppc_checker.sv =====
`timescale 1ns / 1ps

module ppc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input ppc_pkg::in_t                 in_data_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input ppc_pkg::out_t                out_data_o,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [ppc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [ppc_pkg::CfgDataW-1:0] cfg_data_i
);
  import ppc_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  a_pose_and: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.pose_near ==
      (out_data_o.position_near && out_data_o.rotation_near))
    else $error("pose_near mismatch");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.rotation_gap <= AngleMax)
    else $error("angle out of range");

endmodule

bind pose_proximity_check_top ppc_checker u_ppc_checker (.*);
